// ----- hdl/bkpp_pkg.sv -----
// ----------------------------------------------------------------------------
// bkpp_pkg
// shared constants, types and a decode helper for the key packet parser
// ----------------------------------------------------------------------------
package bkpp_pkg;

    // default number of routing payload bytes per packet
    localparam int ROUTING_BYTES_DEF = 5;

    // link framing bytes
    localparam logic [7:0] C_ESC_BYTE     = 8'h1B;
    localparam logic [7:0] C_INFO_ROUTING = 8'h22;
    localparam logic [7:0] C_INFO_BUTTONS = 8'h24;

    // front button masks
    localparam logic [7:0] C_BTN_UP    = 8'h01;
    localparam logic [7:0] C_BTN_ABOVE = 8'h02;
    localparam logic [7:0] C_BTN_BACK  = 8'h04;
    localparam logic [7:0] C_BTN_DOWN  = 8'h08;
    localparam logic [7:0] C_BTN_BELOW = 8'h10;
    localparam logic [7:0] C_BTN_FWD   = 8'h20;

    // event kinds
    localparam logic C_KIND_ROUTING = 1'b0;
    localparam logic C_KIND_BUTTON  = 1'b1;

    // command codes
    localparam logic [5:0] C_CMD_UP      = 6'd0;
    localparam logic [5:0] C_CMD_ABOVE   = 6'd1;
    localparam logic [5:0] C_CMD_BACK    = 6'd2;
    localparam logic [5:0] C_CMD_DOWN    = 6'd3;
    localparam logic [5:0] C_CMD_BELOW   = 6'd4;
    localparam logic [5:0] C_CMD_FWD     = 6'd5;
    localparam logic [5:0] C_CMD_UNKNOWN = 6'd6;

    typedef struct packed {
        logic       kind;
        logic [5:0] code;
    } t_result;

    // single released button to command, anything else is unknown
    function automatic logic [5:0] release_code(input logic [7:0] released);
        logic [5:0] code;
        case (released)
            C_BTN_UP:    code = C_CMD_UP;
            C_BTN_ABOVE: code = C_CMD_ABOVE;
            C_BTN_BACK:  code = C_CMD_BACK;
            C_BTN_DOWN:  code = C_CMD_DOWN;
            C_BTN_BELOW: code = C_CMD_BELOW;
            C_BTN_FWD:   code = C_CMD_FWD;
            default:     code = C_CMD_UNKNOWN;
        endcase
        return code;
    endfunction

endpackage

// ----- hdl/braille_key_packet_parser_unit.sv -----
// ----------------------------------------------------------------------------
// braille_key_packet_parser_unit
// key packet parser for received bytes of a braille display link
// ----------------------------------------------------------------------------
// usage:
//  - slave stream carries one received byte per transaction in tdata and a
//    timeout flag in tuser; a set timeout flag abandons the packet in flight
//  - master stream carries one key event per transaction: tuser is the
//    event kind (routing key or front button), tdata the key code
//  - packets are escape, infotype, then payload; routing packets report the
//    lowest newly pressed cursor key, button packets report a released key
//  - one byte is taken every cycle while the queue tail is free; the parser state
//    registers and the encoder in front of them settle each byte in the cycle
//    it is accepted; the event that a byte raises is registered into the queue
//    and appears on the master side once it reaches the queue head
//  - a two-entry output queue sits between the sides: bytes keep flowing
//    while one event waits, tready drops only when both entries are full
//  - reset clears the parser to hunting for escape, empties the queue and
//    zeroes the held routing and button state
// ----------------------------------------------------------------------------
module braille_key_packet_parser_unit #(
    parameter int ROUTING_BYTES = bkpp_pkg::ROUTING_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // slave stream
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] rx_byte
    input  logic       i_s_axis_tuser,   // [0] timed_out
    // master stream
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [5:0] key_id, [7:6] zero
    output logic       o_m_axis_tuser    // [0] event_kind
);

    import bkpp_pkg::*;

    localparam int IDX_W  = (ROUTING_BYTES > 1) ? $clog2(ROUTING_BYTES) : 1;
    localparam int NBITS  = ROUTING_BYTES * 8;
    localparam int KEY_W  = $clog2(NBITS);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_INFO,
        PH_ROUTE,
        PH_BUTTON
    } t_phase;

    // parser state
    t_phase             r_phase, n_phase;
    logic [IDX_W-1:0]   r_byte_index, n_byte_index;
    logic               r_esc_pending, n_esc_pending;
    logic [7:0]         r_incoming [ROUTING_BYTES];
    logic [7:0]         n_incoming [ROUTING_BYTES];
    logic [7:0]         r_routing_held [ROUTING_BYTES];
    logic [7:0]         n_routing_held [ROUTING_BYTES];
    logic [7:0]         r_buttons_held, n_buttons_held;

    // output queue, entry 0 is the head
    logic               r_v0, n_v0, r_v1, n_v1;
    t_result            r_d0, n_d0, r_d1, n_d1;

    logic               in_acc;
    logic               out_pop;
    logic               res_valid;
    t_result            res;
    logic [NBITS-1:0]   fresh;
    logic               found;
    logic [KEY_W-1:0]   found_idx;
    logic [7:0]         rx;
    logic [7:0]         released;

    assign rx      = i_s_axis_tdata;
    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_pop = r_v0 && i_m_axis_tready;

    assign o_s_axis_tready = !r_v1;
    assign o_m_axis_tvalid = r_v0;
    assign o_m_axis_tdata  = {2'b00, r_d0.code};
    assign o_m_axis_tuser  = r_d0.kind;

    assign released = r_buttons_held & ~rx;

    // new routing bits with the final byte in its slot, masked by held keys
    always_comb begin
        for (int i = 0; i < ROUTING_BYTES; i++) begin
            if (IDX_W'(i) == r_byte_index) begin
                fresh[i*8 +: 8] = rx & ~r_routing_held[i];
            end else begin
                fresh[i*8 +: 8] = r_incoming[i] & ~r_routing_held[i];
            end
        end
    end

    // lowest set bit wins
    always_comb begin
        found     = 1'b0;
        found_idx = '0;
        for (int k = NBITS - 1; k >= 0; k--) begin
            if (fresh[k]) begin
                found     = 1'b1;
                found_idx = KEY_W'(k);
            end
        end
    end

    // parser next state
    always_comb begin
        n_phase        = r_phase;
        n_byte_index   = r_byte_index;
        n_esc_pending  = r_esc_pending;
        n_incoming     = r_incoming;
        n_routing_held = r_routing_held;
        n_buttons_held = r_buttons_held;
        res_valid      = 1'b0;
        res.kind       = C_KIND_ROUTING;
        res.code       = 6'(found_idx);

        if (in_acc) begin
            if (i_s_axis_tuser) begin
                n_phase       = PH_HUNT;
                n_byte_index  = '0;
                n_esc_pending = 1'b0;
            end else begin
                case (r_phase)
                    PH_HUNT: begin
                        if (rx == C_ESC_BYTE) begin
                            n_phase = PH_INFO;
                        end
                    end
                    PH_INFO: begin
                        n_byte_index  = '0;
                        n_esc_pending = 1'b0;
                        if (rx == C_INFO_ROUTING) begin
                            n_phase = PH_ROUTE;
                        end else if (rx == C_INFO_BUTTONS) begin
                            n_phase = PH_BUTTON;
                        end else begin
                            n_phase = PH_HUNT;
                        end
                    end
                    PH_ROUTE: begin
                        if (rx == C_ESC_BYTE && !r_esc_pending) begin
                            // stuffing escape, dropped
                            n_esc_pending = 1'b1;
                        end else begin
                            // a stuffed escape clears the flag, other data keeps it
                            if (rx == C_ESC_BYTE) begin
                                n_esc_pending = 1'b0;
                            end
                            n_incoming[r_byte_index] = rx;
                            if (r_byte_index == IDX_W'(ROUTING_BYTES - 1)) begin
                                for (int i = 0; i < ROUTING_BYTES; i++) begin
                                    n_routing_held[i] = n_incoming[i];
                                end
                                n_phase       = PH_HUNT;
                                n_byte_index  = '0;
                                n_esc_pending = 1'b0;
                                res_valid     = found;
                            end else begin
                                n_byte_index = r_byte_index + 1'b1;
                            end
                        end
                    end
                    PH_BUTTON: begin
                        if (rx == C_ESC_BYTE && !r_esc_pending) begin
                            n_esc_pending = 1'b1;
                        end else begin
                            n_phase       = PH_HUNT;
                            n_esc_pending = 1'b0;
                            if (rx != r_buttons_held) begin
                                n_buttons_held = rx;
                                res.kind       = C_KIND_BUTTON;
                                res.code       = release_code(released);
                                res_valid      = (released != 8'h00);
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_HUNT;
                    end
                endcase
            end
        end
    end

    // output queue: pop shifts the tail forward, push fills the first free entry
    always_comb begin
        n_v0 = r_v0;
        n_v1 = r_v1;
        n_d0 = r_d0;
        n_d1 = r_d1;
        if (out_pop) begin
            n_v0 = r_v1;
            n_d0 = r_d1;
            n_v1 = 1'b0;
        end
        if (res_valid) begin
            if (!n_v0) begin
                n_v0 = 1'b1;
                n_d0 = res;
            end else begin
                n_v1 = 1'b1;
                n_d1 = res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HUNT;
            r_byte_index   <= '0;
            r_esc_pending  <= 1'b0;
            r_buttons_held <= '0;
            for (int i = 0; i < ROUTING_BYTES; i++) begin
                r_routing_held[i] <= '0;
            end
            r_v0           <= 1'b0;
            r_v1           <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_byte_index   <= n_byte_index;
            r_esc_pending  <= n_esc_pending;
            r_buttons_held <= n_buttons_held;
            r_routing_held <= n_routing_held;
            r_v0           <= n_v0;
            r_v1           <= n_v1;
        end
        // payload, no reset
        r_incoming <= n_incoming;
        r_d0       <= n_d0;
        r_d1       <= n_d1;
    end

    // assertions

    // tail entry is only ever used behind a full head
    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> r_v0)
        else $error("output queue tail valid without head");

    // routing byte counter only runs inside a routing payload
    a_index_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_ROUTE) |-> (r_byte_index == '0))
        else $error("byte index nonzero outside routing payload");

    // timeout drops the packet in flight
    a_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_s_axis_tuser) |=> (r_phase == PH_HUNT && !r_esc_pending))
        else $error("timeout did not return parser to hunting");

    // escape while hunting opens a packet
    a_hunt_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_s_axis_tuser && r_phase == PH_HUNT && rx == C_ESC_BYTE)
        |=> (r_phase == PH_INFO))
        else $error("escape while hunting did not move to infotype");

endmodule

// ----- bench/braille_key_packet_parser_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// braille_key_packet_parser_unit_test
// self-checking bench for the braille key packet parser
// ----------------------------------------------------------------------------
// received bytes go in on the slave stream and key events come out on the
// master stream. a scoreboard runs its own copy of the parser on every
// accepted byte and queues the key event that byte should raise. every
// event the block sends is checked against the oldest queued one. the run
// opens with hand-picked packets, then goes on with random well-formed
// packets mixed with line noise, cut packets and timeouts. both sides pause
// at random, with bursts where neither side pauses.
// ----------------------------------------------------------------------------
module braille_key_packet_parser_unit_test;
    import bkpp_pkg::*;

    localparam int ROUTE_N      = ROUTING_BYTES_DEF;
    localparam int RANDOM_ITEMS = 450;
    localparam int STALL_LIMIT  = 2000;  // cycles with no transaction on either side
    localparam int DRAIN_CYCLES = 10;

    // parser phases as the scoreboard tracks them
    typedef enum logic [1:0] {
        HUNT           = 2'd0,
        INFOTYPE       = 2'd1,
        ROUTE_PAYLOAD  = 2'd2,
        BUTTON_PAYLOAD = 2'd3
    } t_parse_phase;

    // ------------------------------------------------------------------------
    // scoreboard: parser copy plus the queue of key events still owed
    // ------------------------------------------------------------------------
    class key_event_scoreboard;
        t_parse_phase phase;
        int           byte_index;
        logic         esc_pending;
        logic [7:0]   routing_new  [ROUTE_N];
        logic [7:0]   routing_held [ROUTE_N];
        logic [7:0]   buttons_held;
        t_result      owed_events[$];
        int           failures;

        function new();
            phase        = HUNT;
            byte_index   = 0;
            esc_pending  = 1'b0;
            buttons_held = 8'h00;
            failures     = 0;
            for (int i = 0; i < ROUTE_N; i++) begin
                routing_new[i]  = 8'h00;
                routing_held[i] = 8'h00;
            end
        endfunction

        function int pending();
            return owed_events.size();
        endfunction

        // advance the parser copy by one accepted byte
        function void note_byte(input logic [7:0] b, input logic tout);
            logic [7:0] fresh;
            logic [7:0] released;
            logic       hit;
            t_result    ev;
            // timeout drops the packet in flight, held keys stay
            if (tout) begin
                phase       = HUNT;
                byte_index  = 0;
                esc_pending = 1'b0;
                return;
            end
            case (phase)
                HUNT: begin
                    if (b == C_ESC_BYTE)
                        phase = INFOTYPE;
                end
                INFOTYPE: begin
                    // an escape here is just an unknown infotype
                    byte_index  = 0;
                    esc_pending = 1'b0;
                    if (b == C_INFO_ROUTING)
                        phase = ROUTE_PAYLOAD;
                    else if (b == C_INFO_BUTTONS)
                        phase = BUTTON_PAYLOAD;
                    else
                        phase = HUNT;
                end
                ROUTE_PAYLOAD: begin
                    // unstuffing: a lone escape is dropped, a second is data;
                    // any other byte after it is data and leaves the flag set
                    if (b == C_ESC_BYTE) begin
                        if (!esc_pending) begin
                            esc_pending = 1'b1;
                            return;
                        end
                        esc_pending = 1'b0;
                    end
                    if (byte_index < ROUTE_N)
                        routing_new[byte_index] = b;
                    byte_index++;
                    if (byte_index < ROUTE_N)
                        return;
                    // lowest key newly pressed against the held bits
                    hit = 1'b0;
                    for (int i = 0; i < ROUTE_N && !hit; i++) begin
                        fresh = routing_new[i] & ~routing_held[i];
                        for (int k = 0; k < 8 && !hit; k++) begin
                            if (fresh[k]) begin
                                ev.kind = C_KIND_ROUTING;
                                ev.code = 6'(i * 8 + k);
                                hit     = 1'b1;
                            end
                        end
                    end
                    if (hit)
                        owed_events.push_back(ev);
                    routing_held = routing_new;
                    phase        = HUNT;
                    byte_index   = 0;
                    esc_pending  = 1'b0;
                end
                BUTTON_PAYLOAD: begin
                    if (b == C_ESC_BYTE && !esc_pending) begin
                        esc_pending = 1'b1;
                        return;
                    end
                    phase       = HUNT;
                    esc_pending = 1'b0;
                    if (b == buttons_held)
                        return;
                    released     = buttons_held & ~b;
                    buttons_held = b;
                    if (released == 8'h00)
                        return;
                    // one of the six front buttons maps to its bit position,
                    // anything else is unknown
                    ev.kind = C_KIND_BUTTON;
                    ev.code = C_CMD_UNKNOWN;
                    if ($countones(released) == 1 && released[7:6] == 2'b00) begin
                        for (int k = 0; k < 6; k++) begin
                            if (released[k])
                                ev.code = 6'(k);
                        end
                    end
                    owed_events.push_back(ev);
                end
            endcase
        endfunction

        // compare one sent key event with the oldest owed one
        function void check_event(input logic kind, input logic [7:0] data);
            t_result want;
            if (owed_events.size() == 0) begin
                $display("%0t: key event with none owed, expected nothing, got kind %0d data %0d",
                         $time, kind, data);
                failures++;
                return;
            end
            want = owed_events.pop_front();
            if (kind !== want.kind) begin
                $display("%0t: event kind mismatch, expected %0d, got %0d",
                         $time, want.kind, kind);
                failures++;
            end
            if (data !== {2'b00, want.code}) begin
                $display("%0t: key code mismatch, expected %0d, got %0d",
                         $time, want.code, data);
                failures++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block under test
    // ------------------------------------------------------------------------
    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic [7:0] s_tdata;     // [7:0] rx_byte
    logic       s_tuser;     // [0] timed_out
    logic       m_tready;
    logic       o_s_axis_tready;
    logic       o_m_axis_tvalid;
    logic [7:0] o_m_axis_tdata;  // [5:0] key_id, [7:6] zero
    logic       o_m_axis_tuser;  // [0] event_kind

    key_event_scoreboard sb;
    logic       burst_mode;      // no pauses on either side while set
    int         ready_hold;
    int         idle_cycles;
    int         sent_bytes;

    always #5 clk = ~clk;

    braille_key_packet_parser_unit #(
        .ROUTING_BYTES(ROUTE_N)
    ) u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // ------------------------------------------------------------------------
    // sender pauses: mostly none or short, now and then long
    // ------------------------------------------------------------------------
    function int pick_gap();
        int r;
        if (burst_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // one byte on the slave stream, held until the transaction completes
    task automatic push_byte(input logic [7:0] b, input logic tout);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom());
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= tout;
        @(posedge clk);
        while (!o_s_axis_tready)
            @(posedge clk);
        sb.note_byte(b, tout);
        sent_bytes++;
    endtask

    // payload byte with escape stuffing, and now and then a stray escape
    // in front of plain data
    task automatic push_payload(input logic [7:0] b);
        if (b == C_ESC_BYTE) begin
            push_byte(C_ESC_BYTE, 1'b0);
            push_byte(C_ESC_BYTE, 1'b0);
        end else begin
            if ($urandom_range(0, 19) == 0)
                push_byte(C_ESC_BYTE, 1'b0);
            push_byte(b, 1'b0);
        end
    endtask

    task automatic send_buttons(input logic [7:0] b);
        push_byte(C_ESC_BYTE, 1'b0);
        push_byte(C_INFO_BUTTONS, 1'b0);
        push_payload(b);
    endtask

    task automatic send_routing(input logic [7:0] payload [ROUTE_N]);
        push_byte(C_ESC_BYTE, 1'b0);
        push_byte(C_INFO_ROUTING, 1'b0);
        for (int i = 0; i < ROUTE_N; i++)
            push_payload(payload[i]);
    endtask

    // ------------------------------------------------------------------------
    // receiver stalls: mostly none or short, now and then long, like the sender pauses
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        int r;
        if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
        end else if (burst_mode) begin
            m_tready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                m_tready   <= 1'b1;
                ready_hold = $urandom_range(0, 7);
            end else if (r < 90) begin
                m_tready   <= 1'b0;
                ready_hold = $urandom_range(0, 2);
            end else begin
                m_tready   <= 1'b0;
                ready_hold = $urandom_range(7, 39);
            end
        end
    end

    // every key event transaction goes to the scoreboard
    always @(posedge clk) begin
        if (rst_n && o_m_axis_tvalid && m_tready)
            sb.check_event(o_m_axis_tuser, o_m_axis_tdata);
    end

    // watchdog on cycles without any transaction
    always @(posedge clk) begin
        if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0] route_bytes [ROUTE_N];
        logic [7:0] b;
        int         pick;
        int         n;

        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'h00;
        s_tuser      = 1'b0;
        m_tready     = 1'b0;
        burst_mode   = 1'b0;
        ready_hold   = 0;
        idle_cycles  = 0;
        sent_bytes   = 0;
        sb           = new();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // escape as infotype goes back to hunting
        push_byte(C_ESC_BYTE, 1'b0);
        push_byte(C_ESC_BYTE, 1'b0);
        // highest routing key
        route_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h80};
        send_routing(route_bytes);
        // lowest key, stuffed escape in the payload, key 39 released quietly
        route_bytes = '{8'hFF, C_ESC_BYTE, 8'h00, 8'h00, 8'h00};
        send_routing(route_bytes);
        // press of all buttons releases nothing, then the same byte again
        send_buttons(8'h3F);
        send_buttons(8'h3F);
        // single release, then several released at once
        send_buttons(8'h3E);
        send_buttons(8'hC0);
        // timeout in the middle of a routing packet
        push_byte(C_ESC_BYTE, 1'b0);
        push_byte(C_INFO_ROUTING, 1'b0);
        push_byte(8'hFF, 1'b1);

        while (sent_bytes < RANDOM_ITEMS) begin
            if ($urandom_range(0, 29) == 0)
                burst_mode = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                // button packet, mostly one key pressed or released
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    b = sb.buttons_held ^ (8'h01 << $urandom_range(0, 5));
                else if (pick < 55)
                    b = sb.buttons_held ^ (8'h01 << $urandom_range(6, 7));
                else if (pick < 70)
                    b = sb.buttons_held;
                else if (pick < 80)
                    b = 8'h00;
                else
                    b = 8'($urandom());
                send_buttons(b);
            end else if (pick < 75) begin
                // routing packet, mostly small changes to the held keys
                for (int i = 0; i < ROUTE_N; i++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 30)
                        route_bytes[i] = sb.routing_held[i];
                    else if (pick < 55)
                        route_bytes[i] = sb.routing_held[i] | (8'h01 << $urandom_range(0, 7));
                    else if (pick < 70)
                        route_bytes[i] = sb.routing_held[i] & 8'($urandom());
                    else if (pick < 80)
                        route_bytes[i] = 8'h00;
                    else if (pick < 88)
                        route_bytes[i] = 8'hFF;
                    else if (pick < 93)
                        route_bytes[i] = C_ESC_BYTE;
                    else
                        route_bytes[i] = 8'($urandom());
                end
                send_routing(route_bytes);
            end else if (pick < 85) begin
                // line noise, escapes now and then
                n = $urandom_range(1, 4);
                repeat (n) begin
                    if ($urandom_range(0, 3) == 0)
                        push_byte(C_ESC_BYTE, 1'b0);
                    else
                        push_byte(8'($urandom()), 1'b0);
                end
            end else if (pick < 95) begin
                // cut packet: random infotype, or partial payload then timeout
                push_byte(C_ESC_BYTE, 1'b0);
                if ($urandom_range(0, 1) == 0) begin
                    push_byte(8'($urandom()), 1'b0);
                end else begin
                    push_byte($urandom_range(0, 1) ? C_INFO_ROUTING : C_INFO_BUTTONS, 1'b0);
                    n = $urandom_range(0, ROUTE_N - 1);
                    repeat (n)
                        push_byte(8'($urandom()), 1'b0);
                    push_byte(8'($urandom()), 1'b1);
                end
            end else begin
                // lone timeout
                push_byte(8'($urandom()), 1'b1);
            end
        end

        // let every owed event come out, then watch for stray events
        s_tvalid <= 1'b0;
        burst_mode = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
